@@ hw/rtl/fsba_pkg.sv @@
// ----------------------------------------------------------------------------
// fsba_pkg
// Shared field types and operation, status and register codes of the free
// sector bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsba_pkg;

	localparam int SEC_W   = 12;
	localparam int TOTAL_W = 13;
	localparam int CFG_IDX_W = 2;

	typedef logic [2:0]          op_t;
	typedef logic [SEC_W-1:0]    sector_t;
	typedef logic [1:0]          status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [TOTAL_W-1:0]  cfg_data_t;

	localparam op_t OP_ALLOC  = 3'd0;
	localparam op_t OP_FREE   = 3'd1;
	localparam op_t OP_MARK   = 3'd2;
	localparam op_t OP_TEST   = 3'd3;
	localparam op_t OP_FORMAT = 3'd4;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NOSPACE = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;

	localparam cfg_idx_t REG_SECTOR_COUNT = 2'd0;
	localparam cfg_idx_t REG_FIRST_DATA   = 2'd1;

	localparam cfg_data_t TOTAL_RESET = 13'd4096;

endpackage

`default_nettype wire

@@ hw/rtl/fsba_req_if.sv @@
// ----------------------------------------------------------------------------
// fsba_req_if
// Request channel: one operation and its sector number per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsba_req_if;
	logic             valid;
	logic             ready;
	fsba_pkg::op_t     op;
	fsba_pkg::sector_t sector;

	modport source (output valid, output op, output sector, input ready);
	modport sink   (input valid, input op, input sector, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fsba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fsba_rsp_if
// Result channel: status, granted sector and tested used bit per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsba_rsp_if;
	logic              valid;
	logic              ready;
	fsba_pkg::status_t status;
	fsba_pkg::sector_t granted_sector;
	logic              is_used;

	modport source (output valid, output status, output granted_sector, output is_used,
		input ready);
	modport sink   (input valid, input status, input granted_sector, input is_used,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fsba_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fsba_cfg_if
// Configuration write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsba_cfg_if;
	logic                valid;
	logic                ready;
	fsba_pkg::cfg_idx_t  index;
	fsba_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/free_sector_bitmap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// free_sector_bitmap_allocator_unit
// First-fit sector allocator over a used-bit map held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an operation (allocate, free, mark used, test, format) and a
//   sector number; rsp returns one result per request: status, granted
//   sector and tested used bit. cfg writes the device sector count (index 0)
//   and first_data_sector (index 1); write it only while the unit is idle.
//   One request is worked at a time. Free, mark used and test pass from
//   request transfer through the word/bit split, whose output issues the
//   memory read, then a write back, then the load of the output
//   register. Allocate scans one map word per cycle from the word holding
//   first_data_sector. Format rewrites every map word, one per cycle.
//   Out-of-range requests, unknown ops and allocates with first_data_sector
//   at or past the sector count skip the map and go straight to the
//   output register. After reset the unit sweeps all MAP_WORDS map words
//   (64 at default size) to zero with req.ready low; cfg writes are taken
//   as ever. A result waits in the output register while rsp stalls; the
//   next request is still taken and worked, and its result holds until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module free_sector_bitmap_allocator_unit #(
	parameter int NUM_SECTORS   = 4096,
	parameter int MAP_WORD_BITS = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fsba_req_if.sink   req,
	fsba_rsp_if.source rsp,
	fsba_cfg_if.sink   cfg
);
	import fsba_pkg::*;

	localparam int WORDS = (NUM_SECTORS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW    = $clog2(WORDS);
	localparam int BW    = $clog2(MAP_WORD_BITS);
	localparam int LW0   = $clog2(NUM_SECTORS + 2 * MAP_WORD_BITS) + 1;
	localparam int LW    = (LW0 > 14) ? LW0 : 14;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOC   = 3'd2;
	localparam logic [2:0] S_WR    = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_FMT   = 3'd5;
	localparam logic [2:0] S_PUSH  = 3'd6;

	// bit b set when b < n
	function automatic logic [MAP_WORD_BITS-1:0] below_mask(input logic [LW-1:0] n);
		logic [MAP_WORD_BITS-1:0] m;
		m = '0;
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			m[b] = LW'(b) < n;
		end
		return m;
	endfunction

	function automatic logic [LW-1:0] span(input logic [LW-1:0] v, input logic [LW-1:0] base);
		return (v > base) ? v - base : '0;
	endfunction

	// configuration
	cfg_data_t total_q;
	sector_t   fds_q;

	logic [2:0] state_q;
	op_t        op_q;
	logic [BW-1:0] bit_q;
	logic [AW-1:0] word_q;

	// sweep and scan pointers
	logic [AW-1:0] fmt_cnt_q;
	logic [LW-1:0] fmt_base_q;
	logic [AW-1:0] iss_word_q;
	logic [LW-1:0] iss_base_q;
	logic          pend_s1;
	logic [AW-1:0] pend_word_s1;
	logic [LW-1:0] pend_base_s1;

	// pending result and output register
	status_t res_status_q;
	sector_t res_granted_q;
	logic    res_used_q;
	logic    out_vld_q;
	status_t out_status_q;
	sector_t out_granted_q;
	logic    out_used_q;

	logic [LW-1:0] limit;
	logic [LW-1:0] fds_ext;
	logic          req_xfer;
	logic          in_range;

	logic          loc_vld;
	sector_t       loc_word;
	logic [BW-1:0] loc_bit;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_rdata;

	logic [MAP_WORD_BITS-1:0] cand;
	logic                     hit;
	logic [BW-1:0]            hit_idx;
	logic                     can_issue;
	logic                     fmt_last;
	logic                     push_ok;
	logic [LW-1:0]            scan_base0;

	assign limit    = (LW'(total_q) > LW'(NUM_SECTORS)) ? LW'(NUM_SECTORS) : LW'(total_q);
	assign fds_ext  = LW'(fds_q);
	assign req_xfer = req.valid && req.ready;
	assign in_range = LW'(req.sector) < limit;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.granted_sector = out_granted_q;
	assign rsp.is_used        = out_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			fds_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SECTOR_COUNT: total_q <= cfg.data;
				REG_FIRST_DATA:   fds_q   <= SEC_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// allocate locates first_data_sector, the others their own sector
	fsba_locate #(
		.WORD_BITS (MAP_WORD_BITS)
	) u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (req_xfer),
		.in_sector ((req.op == OP_ALLOC) ? fds_q : req.sector),
		.out_vld   (loc_vld),
		.out_word  (loc_word),
		.out_bit   (loc_bit)
	);

	fsba_map_ram #(
		.DEPTH (WORDS),
		.WIDTH (MAP_WORD_BITS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// free bits of the word under evaluation, limited to the data area
	assign cand = ~ram_rdata
		& below_mask(span(limit, pend_base_s1))
		& ~below_mask(span(fds_ext, pend_base_s1));
	assign hit = pend_s1 && (cand != '0);

	always_comb begin
		hit_idx = '0;
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_idx = BW'(b);
			end
		end
	end

	assign can_issue  = iss_base_q < limit;
	assign fmt_last   = fmt_cnt_q == AW'(WORDS - 1);
	assign push_ok    = !out_vld_q || rsp.ready;
	assign scan_base0 = fds_ext - LW'(loc_bit);

	// memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = AW'(loc_word);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = fmt_cnt_q;
				ram_wdata = '0;
			end
			S_FMT: begin
				ram_we    = 1'b1;
				ram_waddr = fmt_cnt_q;
				ram_wdata = below_mask(span(fds_ext, fmt_base_q));
			end
			S_LOC: begin
				ram_re = loc_vld;
			end
			S_WR: begin
				ram_we             = (op_q != OP_TEST);
				ram_wdata[bit_q]   = (op_q == OP_MARK);
			end
			S_SCAN: begin
				ram_we            = hit;
				ram_waddr         = pend_word_s1;
				ram_wdata[hit_idx] = 1'b1;
				ram_re            = can_issue;
				ram_raddr         = iss_word_q;
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			fmt_cnt_q <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					fmt_cnt_q <= fmt_cnt_q + AW'(1);
					if (fmt_last) begin
						fmt_cnt_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						case (req.op)
							OP_ALLOC: begin
								state_q <= (fds_ext < limit) ? S_LOC : S_PUSH;
							end
							OP_FREE, OP_MARK, OP_TEST: begin
								state_q <= in_range ? S_LOC : S_PUSH;
							end
							OP_FORMAT: begin
								fmt_cnt_q <= '0;
								state_q   <= S_FMT;
							end
							default: state_q <= S_PUSH;
						endcase
					end
				end
				S_LOC: begin
					if (loc_vld) begin
						pend_s1 <= 1'b1;
						state_q <= (op_q == OP_ALLOC) ? S_SCAN : S_WR;
					end
				end
				S_WR: begin
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					pend_s1 <= can_issue && !hit;
					if (hit || !pend_s1) begin
						pend_s1 <= 1'b0;
						state_q <= S_PUSH;
					end
				end
				S_FMT: begin
					fmt_cnt_q <= fmt_cnt_q + AW'(1);
					if (fmt_last) begin
						fmt_cnt_q <= '0;
						state_q   <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push_ok) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_CLEAR: begin
				fmt_base_q <= fmt_base_q + LW'(MAP_WORD_BITS);
				if (fmt_cnt_q == '0) begin
					fmt_base_q <= LW'(MAP_WORD_BITS);
				end
			end
			S_IDLE: begin
				op_q          <= req.op;
				fmt_base_q    <= '0;
				res_status_q  <= ST_OK;
				res_granted_q <= '0;
				res_used_q    <= 1'b0;
				if (req.op == OP_ALLOC && !(fds_ext < limit)) begin
					res_status_q <= ST_NOSPACE;
				end
				if ((req.op inside {OP_FREE, OP_MARK, OP_TEST}) && !in_range) begin
					res_status_q <= ST_RANGE;
					res_used_q   <= (req.op == OP_TEST);
				end
			end
			S_LOC: begin
				word_q       <= AW'(loc_word);
				bit_q        <= loc_bit;
				pend_word_s1 <= AW'(loc_word);
				pend_base_s1 <= scan_base0;
				iss_word_q   <= AW'(loc_word) + AW'(1);
				iss_base_q   <= scan_base0 + LW'(MAP_WORD_BITS);
			end
			S_WR: begin
				res_used_q <= (op_q == OP_TEST) && ram_rdata[bit_q];
			end
			S_SCAN: begin
				// advance the read pointer; the word read now is evaluated next cycle
				if (can_issue) begin
					pend_word_s1 <= iss_word_q;
					pend_base_s1 <= iss_base_q;
					iss_word_q   <= iss_word_q + AW'(1);
					iss_base_q   <= iss_base_q + LW'(MAP_WORD_BITS);
				end
				if (hit) begin
					res_granted_q <= SEC_W'(pend_base_s1 + LW'(hit_idx));
				end else if (!pend_s1) begin
					res_status_q <= ST_NOSPACE;
				end
			end
			S_FMT: begin
				fmt_base_q <= fmt_base_q + LW'(MAP_WORD_BITS);
			end
			S_PUSH: begin
				if (push_ok) begin
					out_status_q  <= res_status_q;
					out_granted_q <= res_granted_q;
					out_used_q    <= res_used_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/fsba_map_ram.sv @@
// ----------------------------------------------------------------------------
// fsba_map_ram
// Bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsba_map_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fsba_locate.sv @@
// ----------------------------------------------------------------------------
// fsba_locate
// Split a sector number into map word index and bit offset: reciprocal
// multiply into a registered estimate, then one registered correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module fsba_locate #(
	parameter int WORD_BITS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_vld,
	input  wire fsba_pkg::sector_t            in_sector,
	output      logic                         out_vld,
	output      fsba_pkg::sector_t            out_word,
	output      logic [$clog2(WORD_BITS)-1:0] out_bit
);
	import fsba_pkg::*;

	localparam int BW    = $clog2(WORD_BITS);
	localparam int SHIFT = SEC_W + 7;
	localparam int RECIP = (1 << SHIFT) / WORD_BITS;
	localparam int MW    = $clog2(RECIP + 1);

	logic [SEC_W+MW-1:0] prod;
	logic [SEC_W-1:0]    q_s1;
	sector_t             sec_s1;
	logic                vld_s1;
	logic [SEC_W-1:0]    rem;
	logic                over;

	// estimate is exact or one short
	assign prod = (SEC_W+MW)'(in_sector) * (SEC_W+MW)'(RECIP);
	assign rem  = sec_s1 - SEC_W'(q_s1 * WORD_BITS);
	assign over = rem >= SEC_W'(WORD_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= SEC_W'(prod >> SHIFT);
		sec_s1 <= in_sector;
		if (over) begin
			out_word <= q_s1 + SEC_W'(1);
			out_bit  <= BW'(rem - SEC_W'(WORD_BITS));
		end else begin
			out_word <= q_s1;
			out_bit  <= BW'(rem);
		end
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free sector bitmap allocator. A shadow used
// map and shadow registers predict every result at request transfer. The
// bench runs directed cases on the edges of the map and the registers, then
// random phases under several register settings with bursty requests and a
// stalling result sink.
// ----------------------------------------------------------------------------
module tb;
	import fsba_pkg::*;

	localparam int MAP_SIZE      = 4096;
	localparam int QUIET_LIMIT   = 4000;
	localparam int END_HOLD      = 100;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 95;
	localparam int PRINT_CAP     = 100;

	// op codes with no defined meaning; the unit must answer them as no-ops
	localparam op_t OP_RSVD_5 = 3'd5;
	localparam op_t OP_RSVD_6 = 3'd6;
	localparam op_t OP_RSVD_7 = 3'd7;

	// register indexes that select nothing
	localparam cfg_idx_t REG_UNUSED_2 = 2'd2;
	localparam cfg_idx_t REG_UNUSED_3 = 2'd3;

	typedef struct packed {
		status_t status;
		sector_t granted;
		logic    used;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	fsba_req_if req_if ();
	fsba_rsp_if rsp_if ();
	fsba_cfg_if cfg_if ();

	free_sector_bitmap_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Shadow copy of the unit: used map and both registers.
	logic [MAP_SIZE-1:0] shadow_used;
	cfg_data_t           shadow_total;
	sector_t             shadow_first;

	outcome_t pending_outcomes[$];   // results owed by the unit, oldest first
	sector_t  granted_pool[$];       // sectors handed out, candidates to free

	int mismatches = 0;
	int burst_left = 0;

	// Effective sector count: the sector count register capped at the map size.
	function automatic int sector_limit();
		return (shadow_total > MAP_SIZE) ? MAP_SIZE : int'(shadow_total);
	endfunction

	// Apply one request to the shadow state and return the result it owes.
	function automatic outcome_t apply_request(op_t op, sector_t sec);
		outcome_t res;
		int       lim;
		int       s;
		lim = sector_limit();
		res = '0;
		res.status = ST_OK;
		case (op)
			OP_ALLOC: begin
				// first fit from the data start; nothing found means no space
				res.status = ST_NOSPACE;
				for (s = shadow_first; s < lim; s++) begin
					if (!shadow_used[s]) begin
						shadow_used[s] = 1'b1;
						res.status = ST_OK;
						res.granted = sector_t'(s);
						granted_pool.push_back(sector_t'(s));
						break;
					end
				end
			end
			OP_FREE, OP_MARK: begin
				if (sec >= lim) res.status = ST_RANGE;
				else shadow_used[sec] = (op == OP_MARK);
			end
			OP_TEST: begin
				// out-of-range sectors read as used
				if (sec >= lim) begin
					res.status = ST_RANGE;
					res.used = 1'b1;
				end else begin
					res.used = shadow_used[sec];
				end
			end
			OP_FORMAT: begin
				shadow_used = '0;
				for (s = 0; s < shadow_first; s++) shadow_used[s] = 1'b1;
				granted_pool.delete();
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
	endtask

	// Present one request and hold it until the transfer; valid stays high
	// so a back-to-back request can follow without a bubble.
	task automatic send_request(op_t op, sector_t sec);
		req_if.valid  <= 1'b1;
		req_if.op     <= op;
		req_if.sector <= sec;
		do @(posedge clk); while (!req_if.ready);
		pending_outcomes.push_back(apply_request(op, sec));
	endtask

	// Bursts of random length with random gaps; a zero gap keeps valid high.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1, 2:    gap = $urandom_range(1, 4);
				default: gap = $urandom_range(5, 16);
			endcase
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Drop valid and hold until every owed result has come back; at least
	// one edge passes so valid never falls and rises in the same step.
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_SECTOR_COUNT: shadow_total = value;
			REG_FIRST_DATA:   shadow_first = value[SEC_W-1:0];
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset defaults: full map, data from sector zero.
	task automatic test_basic_ops();
		send_request(OP_ALLOC, 12'd0);
		send_request(OP_ALLOC, 12'hFFF);
		send_request(OP_TEST, 12'd0);
		send_request(OP_TEST, 12'hFFF);
		send_request(OP_FREE, 12'd0);
		send_request(OP_TEST, 12'd0);
		send_request(OP_ALLOC, 12'd0);      // reuses the freed sector
		send_request(OP_MARK, 12'hFFF);
		send_request(OP_TEST, 12'hFFF);
		send_request(OP_FREE, 12'hFFF);
		send_request(OP_RSVD_5, 12'hFFF);
		send_request(OP_RSVD_6, 12'h000);
		send_request(OP_RSVD_7, 12'hA5A);
		send_request(OP_FORMAT, 12'h5A5);
		send_request(OP_TEST, 12'd1);
		wait_idle();
	endtask

	// Smallest count, data start on the last sector and past the count, count above the map.
	task automatic test_config_extremes();
		write_reg(REG_SECTOR_COUNT, 13'd70);
		write_reg(REG_FIRST_DATA, 13'd69);
		write_reg(REG_UNUSED_2, 13'h1555);
		write_reg(REG_UNUSED_3, 13'h0AAA);
		send_request(OP_FORMAT, 12'd0);
		send_request(OP_ALLOC, 12'd0);
		send_request(OP_ALLOC, 12'd0);      // map full: no space
		send_request(OP_TEST, 12'd70);      // first sector out of range
		send_request(OP_FREE, 12'hFFF);
		send_request(OP_MARK, 12'd70);
		wait_idle();
		// upper data bit is beyond the register and must be dropped
		write_reg(REG_FIRST_DATA, 13'h1FFF);
		send_request(OP_ALLOC, 12'd0);      // data start past the count
		send_request(OP_FORMAT, 12'd0);     // marks all but the last sector
		wait_idle();
		write_reg(REG_SECTOR_COUNT, 13'h1FFF);
		send_request(OP_ALLOC, 12'd0);
		send_request(OP_ALLOC, 12'd0);
		send_request(OP_TEST, 12'd4094);
		wait_idle();
	endtask

	// One random request, weighted toward allocate and freeing what was
	// handed out so the map fills and drains.
	task automatic random_request();
		int      r;
		int      lim;
		int      idx;
		op_t     op;
		sector_t sec;
		lim = sector_limit();
		r = $urandom_range(0, 99);
		if (r < 46) op = OP_ALLOC;
		else if (r < 66) op = OP_FREE;
		else if (r < 76) op = OP_MARK;
		else if (r < 96) op = OP_TEST;
		else if (r < 97) op = OP_FORMAT;
		else begin
			case ($urandom_range(0, 2))
				0:       op = OP_RSVD_5;
				1:       op = OP_RSVD_6;
				default: op = OP_RSVD_7;
			endcase
		end
		r = $urandom_range(0, 99);
		if (op == OP_FREE && granted_pool.size() > 0 && r < 60) begin
			idx = $urandom_range(0, granted_pool.size() - 1);
			sec = granted_pool[idx];
			granted_pool.delete(idx);
		end else if (r < 70) begin
			sec = sector_t'($urandom_range(0, lim - 1));
		end else if (r < 85) begin
			// boundaries of the count and of the data start
			case ($urandom_range(0, 3))
				0:       sec = sector_t'(lim - 1);
				1:       sec = (lim < MAP_SIZE) ? sector_t'(lim) : sector_t'(MAP_SIZE - 1);
				2:       sec = shadow_first;
				default: sec = (shadow_first > 0) ? shadow_first - 1'b1 : '0;
			endcase
		end else begin
			sec = sector_t'($urandom);
		end
		send_request(op, sec);
	endtask

	task automatic test_random_traffic();
		int        phase;
		int        n;
		int        pick;
		bit        preformat;
		bit        hi_bit;
		cfg_data_t tot;
		sector_t   alloc_first;
		sector_t   fmt_first;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			pick = $urandom_range(0, 5);
			preformat = 1'($urandom_range(0, 1));
			fmt_first = sector_t'($urandom_range(0, 300));
			case (pick)
				0: begin
					tot = 13'd4096;
					alloc_first = sector_t'($urandom_range(0, 100));
				end
				1: begin
					tot = cfg_data_t'($urandom_range(70, 200));
					alloc_first = sector_t'($urandom_range(0, tot / 2));
				end
				2: begin
					tot = cfg_data_t'($urandom_range(70, 8191));
					alloc_first = sector_t'($urandom_range(0, 4095));
				end
				3: begin
					// data start near the top: at most 196 allocates fill the map
					tot = 13'd4096;
					alloc_first = sector_t'($urandom_range(3900, 4095));
				end
				4: begin
					tot = cfg_data_t'($urandom_range(70, 130));
					alloc_first = sector_t'($urandom_range(tot - 8, tot + 4));
				end
				default: begin
					// format with a high data start, then allocate from zero:
					// allocates walk most of the map
					tot = 13'd4096;
					alloc_first = '0;
					preformat = 1'b1;
					fmt_first = sector_t'($urandom_range(3800, 4090));
				end
			endcase
			write_reg(REG_SECTOR_COUNT, tot);
			if (preformat) begin
				hi_bit = 1'($urandom_range(0, 1));
				write_reg(REG_FIRST_DATA, {hi_bit, fmt_first});
				send_request(OP_FORMAT, sector_t'($urandom));
				wait_idle();
			end
			hi_bit = 1'($urandom_range(0, 1));
			write_reg(REG_FIRST_DATA, {hi_bit, alloc_first});
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_request();
				pace_sender();
				// now and then hold off until the unit has answered everything
				if ($urandom_range(0, 99) == 0) wait_idle();
			end
		end
	endtask

	// Result checker: compare each transfer with the oldest owed result.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch($sformatf("result transfer with nothing owed (status %0d)",
					rsp_if.status));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_if.status !== want.status)
					flag_mismatch($sformatf("status got %0d expected %0d",
						rsp_if.status, want.status));
				if (rsp_if.granted_sector !== want.granted)
					flag_mismatch($sformatf("granted_sector got %0d expected %0d",
						rsp_if.granted_sector, want.granted));
				if (rsp_if.is_used !== want.used)
					flag_mismatch($sformatf("is_used got %0d expected %0d",
						rsp_if.is_used, want.used));
			end
		end
	end

	// Result sink: segments of full speed, hard stall, coin flips and a
	// one-in-three pattern.
	initial begin : rsp_stall
		int seg_left;
		int seg_mode;
		seg_left = 0;
		seg_mode = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				case (seg_mode)
					0:       seg_left = $urandom_range(1, 40);
					1:       seg_left = $urandom_range(1, 12);
					default: seg_left = $urandom_range(4, 30);
				endcase
			end
			seg_left--;
			case (seg_mode)
				0:       rsp_if.ready <= 1'b1;
				1:       rsp_if.ready <= 1'b0;
				2:       rsp_if.ready <= 1'($urandom_range(0, 1));
				default: rsp_if.ready <= (seg_left % 3 == 0);
			endcase
		end
	end

	// Watchdog: too many edges in a row without any transfer ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		req_if.valid  <= 1'b0;
		req_if.op     <= OP_ALLOC;
		req_if.sector <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.index  <= REG_SECTOR_COUNT;
		cfg_if.data   <= '0;
		shadow_used   = '0;
		shadow_total  = TOTAL_RESET;
		shadow_first  = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_config_extremes();
		test_random_traffic();

		// drain, then hold a while to catch stray result transfers
		wait_idle();
		repeat (END_HOLD) @(posedge clk);

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
